FILE: rtl/lbcfg_pkg.sv
// Shared types, constants and codes of the load based frequency governor.
// No dependencies; the interfaces, datapath, controller, top level and bench use it by scoped names.
package lbcfg_pkg;

   localparam int NUM_CPUS_DEF    = 8;
   localparam int TABLE_DEPTH_DEF = 32;

   localparam int MODE_W   = 2;
   localparam int CPU_W    = 3;
   localparam int TIME_W   = 64;
   localparam int ENTRY_W  = 5;
   localparam int KHZ_W    = 24;
   localparam int LOAD_W   = 7;
   localparam int PERIOD_W = 22;
   localparam int TLEN_W   = 6;
   localparam int CSR_AW   = 8;
   localparam int CSR_DW   = 24;
   localparam int DELTA_W  = 32;
   localparam int NUM_W    = 39;   // holds 100 * (2^32 - 1)
   localparam int MAXDIV_W = 18;   // holds (2^24 - 1) / 100
   localparam int DIV_STEPS = LOAD_W;
   localparam int BIT_W    = 3;

   localparam logic [LOAD_W-1:0]   PCT_SCALE        = 7'd100;
   localparam logic [1:0]          LONG_IDLE_FACTOR = 2'd2;
   localparam logic [PERIOD_W-1:0] MIN_PERIOD_US    = 22'd10000;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD_US  = 22'd60000;
   localparam logic [KHZ_W-1:0]    KHZ_MAX          = 24'hFFFFFF;

   // x / 100 for 24-bit x as (x * RECIP_100) >> RECIP_SHIFT, exact over the range
   localparam logic [24:0]         RECIP_100     = 25'd21474837;
   localparam int                  RECIP_SHIFT   = 31;
   localparam logic [MAXDIV_W-1:0] MAXDIV_RESET  = 18'd167772;

   typedef enum logic [MODE_W-1:0] {
      MODE_TABLE  = 2'd0,
      MODE_SNAP   = 2'd1,
      MODE_SAMPLE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_PERIOD = 8'd0,
      REG_MIN    = 8'd1,
      REG_MAX    = 8'd2,
      REG_TLEN   = 8'd3
   } csr_reg_type;

   typedef struct packed {
      logic             ready;
      logic             load;
      logic             div_step;
      logic [BIT_W-1:0] div_bit;
      logic             update;
      logic             demand;
      logic             walk_rd;
      logic             walk_chk;
      logic             emit;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] in_mode;
      logic              in_cpu_ok;
      logic [MODE_W-1:0] item_mode;
      logic              item_last;
      logic              walk_stop;
      logic              out_busy;
      logic [TLEN_W-1:0] table_length;
   } status_type;

endpackage

FILE: rtl/lbcfg_ifs.sv
// Channel interfaces of the governor: sample input, result output, register writes.
// Depends on lbcfg_pkg for field widths.
interface lbcfg_req_if;
   logic                              valid;
   logic                              ready;
   logic [lbcfg_pkg::MODE_W-1:0]      mode;
   logic [lbcfg_pkg::CPU_W-1:0]       cpu_index;
   logic [lbcfg_pkg::TIME_W-1:0]      wall_time_us;
   logic [lbcfg_pkg::TIME_W-1:0]      idle_time_us;
   logic [lbcfg_pkg::ENTRY_W-1:0]     entry_index;
   logic [lbcfg_pkg::KHZ_W-1:0]       entry_freq_khz;
   logic                              entry_valid;
   logic [lbcfg_pkg::KHZ_W-1:0]       current_freq_khz;
   logic                              last_cpu;

   modport source (output valid, mode, cpu_index, wall_time_us, idle_time_us, entry_index,
                   entry_freq_khz, entry_valid, current_freq_khz, last_cpu, input ready);
   modport sink (input valid, mode, cpu_index, wall_time_us, idle_time_us, entry_index,
                 entry_freq_khz, entry_valid, current_freq_khz, last_cpu, output ready);
endinterface

interface lbcfg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lbcfg_pkg::LOAD_W-1:0]  peak_load;
   logic [lbcfg_pkg::KHZ_W-1:0]   target_freq_khz;
   logic                          request_change;

   modport source (output valid, peak_load, target_freq_khz, request_change, input ready);
   modport sink (input valid, peak_load, target_freq_khz, request_change, output ready);
endinterface

interface lbcfg_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lbcfg_pkg::CSR_AW-1:0]  index;
   logic [lbcfg_pkg::CSR_DW-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/lbcfg_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lbcfg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lbcfg_datapath.sv
// Datapath: registers, per-CPU snapshot store, frequency table, shared divider, output register.
// Depends on lbcfg_pkg, lbcfg_ifs and lbcfg_ram.
module lbcfg_datapath #(
   parameter int NUM_CPUS    = lbcfg_pkg::NUM_CPUS_DEF,
   parameter int TABLE_DEPTH = lbcfg_pkg::TABLE_DEPTH_DEF,
   localparam int TCW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   lbcfg_req_if.sink             req,
   lbcfg_rsp_if.source           rsp,
   lbcfg_csr_if.sink             csr,
   input  lbcfg_pkg::cmd_type    cmd,
   input  logic [TCW-1:0]        walk_idx,
   output lbcfg_pkg::status_type status
);

   localparam int CAW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int DW  = lbcfg_pkg::DELTA_W;
   localparam int LW  = lbcfg_pkg::LOAD_W;
   localparam int KW  = lbcfg_pkg::KHZ_W;
   localparam int NW  = lbcfg_pkg::NUM_W;
   localparam int STW = LW + 2 * DW;
   localparam int TBW = KW + 1;

   // configuration
   logic [lbcfg_pkg::PERIOD_W-1:0] period_ff;
   logic [KW-1:0]                  min_ff, max_ff;
   logic [lbcfg_pkg::MAXDIV_W-1:0] maxdiv_ff;
   logic [lbcfg_pkg::TLEN_W-1:0]   tlen_ff;
   logic [lbcfg_pkg::PERIOD_W-1:0] period_in;
   logic [KW+24:0]                 recip_prod;

   // item
   logic [lbcfg_pkg::MODE_W-1:0] mode_ff;
   logic [CAW-1:0]               cpu_ff;
   logic [DW-1:0]                wall_ff, idle_ff;
   logic [KW-1:0]                cur_ff;
   logic                         last_ff;
   logic                         capture, cpu_ok;

   // snapshot store
   logic [NUM_CPUS-1:0] cpu_vld_ff;
   logic                rd_vld_ff;
   logic [STW-1:0]      st_rd, st_word, st_wr;
   logic [CAW-1:0]      rd_cpu;

   // divider and load
   logic [NW-1:0] rem_ff, trial;
   logic [DW-1:0] den_ff;
   logic [LW-1:0] q_ff, saved_ff, peak_ff, saved_in, load_v;
   logic          sat_ff, zero_ff, inval_ff, long_ff;
   logic [DW-1:0] last_w, last_i, wd, id, busy, den, long_lim;

   // demand and table walk
   logic [LW+lbcfg_pkg::MAXDIV_W-1:0] dem_prod;
   logic [KW-1:0]  dem_raw, dem_min, dem_ff, lo_ff, hi_ff, target;
   logic           hit_ff, tbl_ok;
   logic [TBW-1:0] tbl_rd;
   logic           tbl_use;
   logic [KW-1:0]  tbl_f;

   // output register
   logic          out_vld_ff, out_chg_ff;
   logic [LW-1:0] out_peak_ff;
   logic [KW-1:0] out_tgt_ff;

   assign capture = req.valid && cmd.ready;
   assign cpu_ok  = (7'(req.cpu_index) < 7'(NUM_CPUS));
   assign rd_cpu  = CAW'(req.cpu_index);
   assign req.ready = cmd.ready;
   assign csr.ready = 1'b1;

   // register writes
   assign recip_prod = csr.data * lbcfg_pkg::RECIP_100;
   always_comb begin
      period_in = csr.data[lbcfg_pkg::PERIOD_W-1:0];
      if (period_in < lbcfg_pkg::MIN_PERIOD_US) begin
         period_in = lbcfg_pkg::MIN_PERIOD_US;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= lbcfg_pkg::RESET_PERIOD_US;
         min_ff    <= '0;
         max_ff    <= lbcfg_pkg::KHZ_MAX;
         maxdiv_ff <= lbcfg_pkg::MAXDIV_RESET;
         tlen_ff   <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            lbcfg_pkg::REG_PERIOD: period_ff <= period_in;
            lbcfg_pkg::REG_MIN:    min_ff <= csr.data;
            lbcfg_pkg::REG_MAX: begin
               max_ff    <= csr.data;
               maxdiv_ff <= recip_prod[lbcfg_pkg::RECIP_SHIFT +: lbcfg_pkg::MAXDIV_W];
            end
            lbcfg_pkg::REG_TLEN:   tlen_ff <= csr.data[lbcfg_pkg::TLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // capture the item; only the low 32 bits of the times matter for deltas
   always_ff @(posedge clock) begin
      if (capture) begin
         mode_ff <= req.mode;
         cpu_ff  <= rd_cpu;
         wall_ff <= req.wall_time_us[DW-1:0];
         idle_ff <= req.idle_time_us[DW-1:0];
         cur_ff  <= req.current_freq_khz;
         last_ff <= req.last_cpu;
      end
   end

   // snapshot store: entries never written read as zero
   lbcfg_ram #(.WIDTH(STW), .DEPTH(NUM_CPUS)) u_state_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (cpu_ff),
      .wr_data (st_wr),
      .rd_en   (capture),
      .rd_addr (rd_cpu),
      .rd_data (st_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (capture) begin
            rd_vld_ff <= cpu_ok && cpu_vld_ff[rd_cpu];
         end
         if (cmd.update) begin
            cpu_vld_ff[cpu_ff] <= 1'b1;
         end
      end
   end

   assign st_word = rd_vld_ff ? st_rd : '0;
   assign last_w  = st_word[2*DW-1:DW];
   assign last_i  = st_word[DW-1:0];

   // window deltas
   assign long_lim = DW'(period_ff) * DW'(lbcfg_pkg::LONG_IDLE_FACTOR);
   always_comb begin
      wd = wall_ff - last_w;
      id = idle_ff - last_i;
      if (mode_ff == lbcfg_pkg::MODE_SNAP) begin
         busy = wall_ff - idle_ff;
         den  = wall_ff;
      end else begin
         busy = wd - id;
         den  = wd;
      end
   end

   assign trial = NW'(den_ff) << cmd.div_bit;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff   <= NW'(busy) * NW'(lbcfg_pkg::PCT_SCALE);
         den_ff   <= den;
         q_ff     <= '0;
         saved_ff <= st_word[STW-1:2*DW];
         sat_ff   <= (busy >= den);
         zero_ff  <= (den == '0);
         inval_ff <= (wd == '0) || (id > wd);
         long_ff  <= (wd > long_lim) && (st_word[STW-1:2*DW] != '0);
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            q_ff[cmd.div_bit] <= 1'b1;
         end
      end
   end

   // new saved load and the load that joins the round
   always_comb begin
      saved_in = saved_ff;
      load_v   = '0;
      if (mode_ff == lbcfg_pkg::MODE_SNAP) begin
         saved_in = zero_ff ? '0 : (sat_ff ? lbcfg_pkg::PCT_SCALE : q_ff);
      end else if (!inval_ff) begin
         if (long_ff) begin
            load_v   = saved_ff;
            saved_in = '0;
         end else begin
            load_v   = q_ff;
            saved_in = q_ff;
         end
      end
   end

   assign st_wr = {saved_in, wall_ff, idle_ff};

   // demand
   assign dem_prod = peak_ff * maxdiv_ff;
   assign dem_raw  = dem_prod[KW-1:0];
   assign dem_min  = (dem_raw < min_ff) ? min_ff : dem_raw;

   // hold the round peak until its result is loaded, then clear it
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else if (cmd.update) begin
         if (load_v > peak_ff) begin
            peak_ff <= load_v;
         end
      end else if (cmd.emit) begin
         peak_ff <= '0;
      end
   end

   // frequency table: written straight from a table item
   assign tbl_ok = capture && (req.mode == lbcfg_pkg::MODE_TABLE)
                   && (9'(req.entry_index) < 9'(TABLE_DEPTH));

   lbcfg_ram #(.WIDTH(TBW), .DEPTH(TABLE_DEPTH)) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_ok),
      .wr_addr (TAW'(req.entry_index)),
      .wr_data ({req.entry_valid, req.entry_freq_khz}),
      .rd_en   (cmd.walk_rd),
      .rd_addr (walk_idx[TAW-1:0]),
      .rd_data (tbl_rd)
   );

   assign tbl_use = tbl_rd[KW];
   assign tbl_f   = tbl_rd[KW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.demand) begin
         dem_ff      <= (dem_min > max_ff) ? max_ff : dem_min;
         lo_ff       <= '0;
         hi_ff       <= '0;
         hit_ff      <= 1'b0;
      end else if (cmd.walk_chk && tbl_use) begin
         if (tbl_f < dem_ff) begin
            lo_ff <= tbl_f;
         end else begin
            hi_ff  <= tbl_f;
            hit_ff <= (tbl_f == dem_ff);
         end
      end
   end

   always_comb begin
      if (hit_ff) begin
         target = hi_ff;
      end else if (cur_ff >= lo_ff && cur_ff <= hi_ff) begin
         target = cur_ff;
      end else begin
         target = hi_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_peak_ff <= peak_ff;
         out_tgt_ff  <= target;
         out_chg_ff  <= (target != '0) && (target != cur_ff);
      end
   end

   assign rsp.valid           = out_vld_ff;
   assign rsp.peak_load       = out_peak_ff;
   assign rsp.target_freq_khz = out_tgt_ff;
   assign rsp.request_change  = out_chg_ff;

   assign status.in_mode      = req.mode;
   assign status.in_cpu_ok    = cpu_ok;
   assign status.item_mode    = mode_ff;
   assign status.item_last    = last_ff;
   assign status.walk_stop    = tbl_use && (tbl_f >= dem_ff);
   assign status.out_busy     = out_vld_ff && !rsp.ready;
   assign status.table_length = tlen_ff;

`ifndef SYNTHESIS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !out_vld_ff || rsp.ready)
      else $error("result loaded over a pending transfer");
   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      peak_ff <= lbcfg_pkg::PCT_SCALE)
      else $error("round peak above full scale");
   a_change_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp.request_change == ((rsp.target_freq_khz != '0)
                                            && (rsp.target_freq_khz != $past(cur_ff)))))
      else $error("change request inconsistent with target");
`endif

endmodule

FILE: rtl/lbcfg_ctrl.sv
// Controller: sequences an item through snapshot read, divide, update, demand and table walk.
// Depends on lbcfg_pkg.
module lbcfg_ctrl #(
   parameter int TABLE_DEPTH = lbcfg_pkg::TABLE_DEPTH_DEF,
   localparam int TCW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  lbcfg_pkg::status_type status,
   output lbcfg_pkg::cmd_type    cmd,
   output logic [TCW-1:0]        walk_idx
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_DIV, ST_UPDATE, ST_DEMAND, ST_WALK, ST_RESULT
   } state_type;

   state_type                   state_ff, state_in;
   logic [lbcfg_pkg::BIT_W-1:0] bit_ff;
   logic [TCW-1:0]              idx_ff, n_len;
   logic                        chk_ff, issue, capture, work;

   always_comb begin
      if (9'(status.table_length) > 9'(TABLE_DEPTH)) begin
         n_len = TCW'(TABLE_DEPTH);
      end else begin
         n_len = TCW'(status.table_length);
      end
   end

   assign issue   = (state_ff == ST_WALK) && (idx_ff < n_len);
   assign capture = (state_ff == ST_IDLE) && req_valid;
   assign work    = status.in_cpu_ok && ((status.in_mode == lbcfg_pkg::MODE_SNAP)
                                        || (status.in_mode == lbcfg_pkg::MODE_SAMPLE));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (capture && work) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIV;
         ST_DIV:    if (bit_ff == '0) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (status.item_mode == lbcfg_pkg::MODE_SAMPLE && status.item_last) begin
               state_in = ST_DEMAND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DEMAND: state_in = ST_WALK;
         ST_WALK: begin
            if ((chk_ff && status.walk_stop) || (!chk_ff && !issue)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: if (!status.out_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '0;
         idx_ff   <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_LOAD) begin
            bit_ff <= lbcfg_pkg::BIT_W'(lbcfg_pkg::DIV_STEPS - 1);
         end else if (state_ff == ST_DIV) begin
            bit_ff <= bit_ff - 1'b1;
         end
         if (state_ff == ST_DEMAND) begin
            idx_ff <= '0;
            chk_ff <= 1'b0;
         end else if (state_ff == ST_WALK) begin
            idx_ff <= idx_ff + TCW'(issue);
            chk_ff <= issue;
         end
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.ready    = (state_ff == ST_IDLE);
      cmd.load     = (state_ff == ST_LOAD);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.div_bit  = bit_ff;
      cmd.update   = (state_ff == ST_UPDATE);
      cmd.demand   = (state_ff == ST_DEMAND);
      cmd.walk_rd  = issue;
      cmd.walk_chk = (state_ff == ST_WALK) && chk_ff;
      cmd.emit     = (state_ff == ST_RESULT) && !status.out_busy;
   end

   assign walk_idx = idx_ff;

`ifndef SYNTHESIS
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff <= n_len))
      else $error("table walk past the table length");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (state_ff == ST_DIV)
                                && (bit_ff == lbcfg_pkg::BIT_W'(lbcfg_pkg::DIV_STEPS - 1)))
      else $error("divider not started at its top bit");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.ready)
      else $error("item accepted while one is at work");
`endif

endmodule

FILE: rtl/load_based_cpu_frequency_governor_unit.sv
// Top level of the load based CPU frequency governor: controller plus datapath.
// Depends on lbcfg_pkg, lbcfg_ifs, lbcfg_ram, lbcfg_datapath and lbcfg_ctrl.

// The block takes one item at a time on req_ch. A table write (mode 0) is written into
// the table RAM on its transfer. A start snapshot goes through transfer, snapshot read,
// seven steps of the shared restoring divider (one quotient bit per cycle), and the
// snapshot update. A periodic sample that does not end the round takes the same steps;
// one that ends the round adds the demand step, a pipelined walk of the frequency table
// (one entry a cycle from the table RAM, stopping at the first usable entry at or above
// the demand or at the table length) and the result load. A finished result waits in
// the output register while the next item is taken. Per-CPU snapshots live in a RAM
// with one valid bit per CPU, so no clearing pass follows reset. Register writes
// on csr_ch are always taken and should be made while no item is in flight.
module load_based_cpu_frequency_governor_unit #(
   parameter int NUM_CPUS    = lbcfg_pkg::NUM_CPUS_DEF,
   parameter int TABLE_DEPTH = lbcfg_pkg::TABLE_DEPTH_DEF
) (
   input logic          clock,
   input logic          reset,
   lbcfg_req_if.sink    req_ch,
   lbcfg_rsp_if.source  rsp_ch,
   lbcfg_csr_if.sink    csr_ch
);

   localparam int TCW = $clog2(TABLE_DEPTH + 1);

   lbcfg_pkg::cmd_type    cmd;
   lbcfg_pkg::status_type status;
   logic [TCW-1:0]        walk_idx;

   // sequence each item; the controller sees the datapath only through cmd and status
   lbcfg_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .cmd       (cmd),
      .walk_idx  (walk_idx)
   );

   // hold configuration, snapshots, table, divider and the output register
   lbcfg_datapath #(.NUM_CPUS(NUM_CPUS), .TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .csr      (csr_ch),
      .cmd      (cmd),
      .walk_idx (walk_idx),
      .status   (status)
   );

endmodule

FILE: bench/load_based_cpu_frequency_governor_unit_tb.sv
// Self-checking testbench of the load based CPU frequency governor.
// It drives table writes, snapshots and samples, predicts each round's result and compares it.
// Depends on lbcfg_pkg, lbcfg_ifs and the RTL of the governor.
module load_based_cpu_frequency_governor_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int LW  = lbcfg_pkg::LOAD_W;
   localparam int KW  = lbcfg_pkg::KHZ_W;
   localparam int PW  = lbcfg_pkg::PERIOD_W;
   localparam int TW  = lbcfg_pkg::TLEN_W;
   localparam int NC  = lbcfg_pkg::NUM_CPUS_DEF;
   localparam int TD  = lbcfg_pkg::TABLE_DEPTH_DEF;

   logic clock;
   logic reset;

   lbcfg_req_if req_ch ();
   lbcfg_rsp_if rsp_ch ();
   lbcfg_csr_if csr_ch ();

   load_based_cpu_frequency_governor_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   typedef struct {
      logic [LW-1:0] peak;
      logic [KW-1:0] target;
      logic          change;
   } round_result_type;

   // Governor state as the bench sees it.
   logic [PW-1:0]       gov_period;
   logic [KW-1:0]       gov_min;
   logic [KW-1:0]       gov_max;
   logic [TW-1:0]       gov_tlen;
   logic [63:0]         snap_wall [NC];
   logic [63:0]         snap_idle [NC];
   logic [LW-1:0]       cpu_saved [NC];
   logic [LW-1:0]       peak_now;
   logic [KW-1:0]       ftab      [TD];
   logic                ftab_ok   [TD];

   round_result_type pending_rounds[$];
   int  error_count;
   int  idle_cycles;
   bit  rx_idle_en;
   bit  tx_idle_en;
   bit  rx_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Snap a clamped demand onto the ascending table, keeping the current
   // frequency when it sits between the neighbors.
   function automatic logic [KW-1:0] pick_freq(logic [31:0] demand, logic [KW-1:0] cur);
      logic [31:0] lo;
      logic [31:0] hi;
      int n;
      lo = '0;
      hi = '0;
      if (demand < 32'(gov_min)) demand = 32'(gov_min);
      if (demand > 32'(gov_max)) demand = 32'(gov_max);
      n = (int'(gov_tlen) > TD) ? TD : int'(gov_tlen);
      for (int i = 0; i < n; i++) begin
         if (!ftab_ok[i]) continue;
         if (32'(ftab[i]) < demand) lo = 32'(ftab[i]);
         if (32'(ftab[i]) == demand) return ftab[i];
         if (32'(ftab[i]) > demand) begin
            hi = 32'(ftab[i]);
            break;
         end
      end
      if (32'(cur) >= lo && 32'(cur) <= hi) return cur;
      return hi[KW-1:0];
   endfunction

   // Advance the governor state by one accepted item and queue any round result.
   task automatic predict_item(logic [1:0] mode, logic [2:0] cpu, logic [63:0] wall,
                               logic [63:0] idle, logic [4:0] slot, logic [KW-1:0] efreq,
                               logic evalid, logic [KW-1:0] cur, logic last);
      logic [63:0] busy;
      logic [63:0] w;
      logic [63:0] ld;
      logic [63:0] wd;
      logic [63:0] id;
      logic [31:0] demand;
      round_result_type r;
      if (mode == lbcfg_pkg::MODE_TABLE) begin
         ftab[slot]    = efreq;
         ftab_ok[slot] = evalid;
         return;
      end
      if (mode != lbcfg_pkg::MODE_SNAP && mode != lbcfg_pkg::MODE_SAMPLE) return;
      if (mode == lbcfg_pkg::MODE_SNAP) begin
         busy = {32'd0, 32'(wall - idle)};
         w    = {32'd0, wall[31:0]};
         ld   = '0;
         snap_wall[cpu] = wall;
         snap_idle[cpu] = idle;
         if (w != 0) begin
            ld = (64'd100 * busy) / w;
            if (ld > 64'd100) ld = 64'd100;
         end
         cpu_saved[cpu] = ld[LW-1:0];
         return;
      end
      wd = {32'd0, 32'(wall - snap_wall[cpu])};
      id = {32'd0, 32'(idle - snap_idle[cpu])};
      snap_wall[cpu] = wall;
      snap_idle[cpu] = idle;
      if (wd != 0 && wd >= id) begin
         if (wd > 64'd2 * 64'(gov_period) && cpu_saved[cpu] != 0) begin
            ld = 64'(cpu_saved[cpu]);
            cpu_saved[cpu] = '0;
         end else begin
            ld = (64'd100 * (wd - id)) / wd;
            cpu_saved[cpu] = ld[LW-1:0];
         end
         if (ld > 64'(peak_now)) peak_now = ld[LW-1:0];
      end
      if (!last) return;
      demand   = 32'(peak_now) * (32'(gov_max) / 32'd100);
      r.peak   = peak_now;
      r.target = pick_freq(demand, cur);
      r.change = (r.target != 0 && r.target != cur);
      pending_rounds.push_back(r);
      peak_now = '0;
   endtask

   // Send one item; idle at random beforehand, hold valid until the transfer.
   // Valid stays up after the transfer so that the next item follows with no gap.
   task automatic send_item(logic [1:0] mode, logic [2:0] cpu, logic [63:0] wall,
                            logic [63:0] idle, logic [4:0] slot, logic [KW-1:0] efreq,
                            logic evalid, logic [KW-1:0] cur, logic last);
      csr_ch.valid <= 1'b0;
      while (tx_idle_en && $urandom_range(99) < 20) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.mode             <= mode;
      req_ch.cpu_index        <= cpu;
      req_ch.wall_time_us     <= wall;
      req_ch.idle_time_us     <= idle;
      req_ch.entry_index      <= slot;
      req_ch.entry_freq_khz   <= efreq;
      req_ch.entry_valid      <= evalid;
      req_ch.current_freq_khz <= cur;
      req_ch.last_cpu         <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_item(mode, cpu, wall, idle, slot, efreq, evalid, cur, last);
   endtask

   task automatic write_reg(lbcfg_pkg::csr_reg_type idx, logic [lbcfg_pkg::CSR_DW-1:0] value);
      req_ch.valid <= 1'b0;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         lbcfg_pkg::REG_PERIOD: begin
            gov_period = value[PW-1:0];
            if (gov_period < lbcfg_pkg::MIN_PERIOD_US) gov_period = lbcfg_pkg::MIN_PERIOD_US;
         end
         lbcfg_pkg::REG_MIN: gov_min = value[KW-1:0];
         lbcfg_pkg::REG_MAX: gov_max = value[KW-1:0];
         lbcfg_pkg::REG_TLEN: gov_tlen = value[TW-1:0];
         default: ;
      endcase
   endtask

   // Drop both valids, let every expected round arrive, then let a trailing item finish.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      csr_ch.valid <= 1'b0;
      while (pending_rounds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Fill the table with an ascending ladder; some slots marked unusable when holes is set.
   task automatic load_ladder(int count, logic [KW-1:0] base, logic [KW-1:0] step,
                              bit holes);
      for (int i = 0; i < count; i++)
         send_item(lbcfg_pkg::MODE_TABLE, 3'd0, 64'd0, 64'd0, i[4:0],
                   KW'(32'(base) + 32'(step) * i),
                   holes ? ($urandom_range(4) != 0) : 1'b1, '0, 1'b0);
   endtask

   // Drive one well-formed round: samples for some cpus, the last one ends it.
   task automatic run_round(int ncpu, logic [KW-1:0] cur);
      logic [63:0] w;
      logic [63:0] d;
      for (int c = 0; c < ncpu; c++) begin
         case ($urandom_range(9))
            0: d = '0;
            1: d = 64'd200000 + 64'($urandom_range(1000000));
            2: d = {$urandom, $urandom};
            default: d = 64'($urandom_range(100000));
         endcase
         w = snap_wall[c] + d;
         send_item(lbcfg_pkg::MODE_SAMPLE, c[2:0], w,
                   snap_idle[c] + (($urandom_range(19) == 0) ? d + 64'd1 :
                                   (d == 0 ? 64'd0 : {32'd0, $urandom} % (d + 64'd1))),
                   5'd0, '0, 1'b0, cur, c == ncpu - 1);
      end
   endtask

   // Result checker: pops the oldest expected round on every transfer.
   always @(posedge clock) begin
      round_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rounds.size() == 0) begin
            $display("%0t: unexpected result peak=%0d target=%0d", $time,
                     rsp_ch.peak_load, rsp_ch.target_freq_khz);
            error_count++;
         end else begin
            exp_r = pending_rounds.pop_front();
            if (rsp_ch.peak_load !== exp_r.peak) begin
               $display("%0t: peak_load expected %0d actual %0d", $time, exp_r.peak,
                        rsp_ch.peak_load);
               error_count++;
            end
            if (rsp_ch.target_freq_khz !== exp_r.target) begin
               $display("%0t: target_freq_khz expected %0d actual %0d", $time,
                        exp_r.target, rsp_ch.target_freq_khz);
               error_count++;
            end
            if (rsp_ch.request_change !== exp_r.change) begin
               $display("%0t: request_change expected %0b actual %0b", $time,
                        exp_r.change, rsp_ch.request_change);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off while the sender keeps going.
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= !rx_hold && !(rx_idle_en && $urandom_range(99) < 20);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Directed: table extremes, snapshot corner cases, invalid windows, ignored items.
   task automatic test_directed();
      write_reg(lbcfg_pkg::REG_TLEN, 24'd8);
      load_ladder(8, 24'd300000, 24'd200000, 1'b0);
      send_item(lbcfg_pkg::MODE_TABLE, 3'd0, 64'd0, 64'd0, 5'd31, 24'hFFFFFF, 1'b0, '0, 1'b0);
      send_item(lbcfg_pkg::MODE_SNAP, 3'd0, 64'd1000, 64'd250, 5'd0, '0, 1'b0, '0, 1'b0);
      send_item(lbcfg_pkg::MODE_SNAP, 3'd1, 64'h1_0000_0000, 64'd5, 5'd0, '0, 1'b0, '0, 1'b0);
      send_item(lbcfg_pkg::MODE_SNAP, 3'd2, 64'd100, 64'd500, 5'd0, '0, 1'b0, '0, 1'b0);
      send_item(lbcfg_pkg::MODE_SNAP, 3'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                5'd0, '0, 1'b0, '0, 1'b0);
      send_item(lbcfg_pkg::MODE_NONE, 3'd7, '1, '1, '1, '1, 1'b1, '1, 1'b1);
      send_item(lbcfg_pkg::MODE_SAMPLE, 3'd0, 64'd1000, 64'd250, 5'd0, '0, 1'b0,
                24'd500000, 1'b0);
      send_item(lbcfg_pkg::MODE_SAMPLE, 3'd1, 64'h1_0000_0000 + 64'd500000, 64'd600000,
                5'd0, '0, 1'b0, '0, 1'b0);
      send_item(lbcfg_pkg::MODE_SAMPLE, 3'd2, 64'd200100, 64'd50, 5'd0, '0, 1'b0,
                24'd500000, 1'b0);
      send_item(lbcfg_pkg::MODE_SAMPLE, 3'd3, 64'd5000, 64'd10000, 5'd0, '0, 1'b0,
                24'd500000, 1'b0);
      send_item(lbcfg_pkg::MODE_SAMPLE, 3'd7, 64'd2000, 64'd0, 5'd0, '0, 1'b0,
                24'd700000, 1'b1);
      send_item(lbcfg_pkg::MODE_SAMPLE, 3'd7, 64'd3000, 64'd1000, 5'd0, '0, 1'b0,
                24'hFFFFFF, 1'b1);
      send_item(lbcfg_pkg::MODE_SAMPLE, 3'd6, 64'd0, 64'd0, 5'd0, '0, 1'b0, 24'd0, 1'b1);
      wait_idle();
   endtask

   // Register settings: min above max, table length past the depth, small period.
   task automatic test_registers();
      load_ladder(32, 24'd100000, 24'd400000, 1'b1);
      write_reg(lbcfg_pkg::REG_TLEN, 24'd63);
      write_reg(lbcfg_pkg::REG_PERIOD, 24'd0);
      write_reg(lbcfg_pkg::REG_MIN, 24'd9000000);
      write_reg(lbcfg_pkg::REG_MAX, 24'd2000000);
      repeat (3) run_round(4, 24'd3000000);
      wait_idle();
      write_reg(lbcfg_pkg::REG_MIN, 24'd0);
      write_reg(lbcfg_pkg::REG_MAX, 24'd0);
      write_reg(lbcfg_pkg::REG_PERIOD, 24'h3FFFFF);
      repeat (2) run_round(3, 24'd0);
      wait_idle();
      write_reg(lbcfg_pkg::REG_MAX, 24'hFFFFFF);
      write_reg(lbcfg_pkg::REG_MIN, 24'hFFFFFF);
      write_reg(lbcfg_pkg::REG_TLEN, 24'd0);
      repeat (2) run_round(2, 24'd100);
      wait_idle();
   endtask

   // Long receiver hold-off while rounds keep coming.
   task automatic test_backpressure();
      write_reg(lbcfg_pkg::REG_MIN, 24'd0);
      write_reg(lbcfg_pkg::REG_PERIOD, 24'd60000);
      write_reg(lbcfg_pkg::REG_TLEN, 24'd32);
      rx_hold = 1'b1;
      fork
         repeat (600) @(posedge clock);
         repeat (8) run_round(1, 24'd900000);
      join_any
      rx_hold = 1'b0;
      wait fork;
      wait_idle();
   endtask

   // Random phases of rounds with a sprinkle of noise and table rewrites.
   task automatic test_random();
      for (int ph = 0; ph < 6; ph++) begin
         tx_idle_en = (ph != 2);
         rx_idle_en = (ph != 2);
         write_reg(lbcfg_pkg::REG_PERIOD, 24'($urandom_range(4000000, 10000)));
         write_reg(lbcfg_pkg::REG_MIN, 24'($urandom_range(3000000)));
         write_reg(lbcfg_pkg::REG_MAX,
                   (ph == 5) ? 24'hFFFFFF : 24'($urandom_range(16777215, 2000000)));
         write_reg(lbcfg_pkg::REG_TLEN, 24'($urandom_range(32, 1)));
         if (ph % 2 == 1) load_ladder(32, 24'($urandom_range(200000)),
                                      24'($urandom_range(500000, 1)), 1'b1);
         for (int k = 0; k < 25; k++) begin
            case ($urandom_range(9))
               0: send_item(lbcfg_pkg::MODE_SNAP, 3'($urandom_range(7)), {$urandom, $urandom},
                            {$urandom, $urandom}, 5'd0, '0, 1'b0, '0, 1'b0);
               1: send_item(lbcfg_pkg::MODE_NONE, 3'($urandom_range(7)), {$urandom, $urandom},
                            {$urandom, $urandom}, 5'($urandom), 24'($urandom), 1'($urandom),
                            24'($urandom), 1'($urandom));
               default: run_round($urandom_range(8, 1),
                                  ($urandom_range(2) == 0) ? 24'($urandom) :
                                  24'($urandom_range(12000000)));
            endcase
         end
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      error_count = 0;
      peak_now = '0;
      rx_idle_en = 1'b1;
      tx_idle_en = 1'b1;
      rx_hold = 1'b0;
      gov_period = lbcfg_pkg::RESET_PERIOD_US;
      gov_min = '0;
      gov_max = lbcfg_pkg::KHZ_MAX;
      gov_tlen = '0;
      for (int i = 0; i < NC; i++) begin
         snap_wall[i] = '0;
         snap_idle[i] = '0;
         cpu_saved[i] = '0;
      end
      for (int i = 0; i < TD; i++) begin
         ftab[i] = '0;
         ftab_ok[i] = 1'b0;
      end
      req_ch.valid <= 1'b0;
      req_ch.mode <= lbcfg_pkg::MODE_TABLE;
      req_ch.cpu_index <= '0;
      req_ch.wall_time_us <= '0;
      req_ch.idle_time_us <= '0;
      req_ch.entry_index <= '0;
      req_ch.entry_freq_khz <= '0;
      req_ch.entry_valid <= 1'b0;
      req_ch.current_freq_khz <= '0;
      req_ch.last_cpu <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= lbcfg_pkg::REG_PERIOD;
      csr_ch.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_backpressure();
      test_random();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
